// ===== design/ste_pkg.sv =====
// Shared types, constants and UTF-8 helpers for the script text extractor.
// No dependencies; imported by all design modules but the checker.
package ste_pkg;

	typedef enum logic [2:0] {
		MODE_SCAN     = 3'd0,
		MODE_TEXT_LEN = 3'd1,
		MODE_SKIP_LEN = 3'd2,
		MODE_TEXT_LO  = 3'd3,
		MODE_TEXT_HI  = 3'd4,
		MODE_SKIP_LO  = 3'd5,
		MODE_SKIP_HI  = 3'd6
	} mode_t;

	localparam logic [7:0]  OP_TEXT_A   = 8'h02;
	localparam logic [7:0]  OP_TEXT_B   = 8'h03;
	localparam logic [7:0]  OP_SKIP     = 8'h30;
	localparam logic [7:0]  OP_SECOND   = 8'h88;
	localparam logic [7:0]  CHAR_CR     = 8'h0D;
	localparam logic [7:0]  CHAR_LF     = 8'h0A;
	localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
	localparam logic [5:0]  SURR_HIGH   = 6'b110110;
	localparam logic [5:0]  SURR_LOW    = 6'b110111;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// one group of results: [U+FFFD][code point][U+FFFD][CR LF]
	typedef struct packed {
		logic        pre;
		logic        cpv;
		logic [20:0] cp;
		logic        post;
		logic        crlf;
	} cmd_t;

	function automatic logic [1:0] utf8_last(input logic [20:0] cp);
		logic [1:0] n;
		begin
			if (cp < 21'h80)
				n = 2'd0;
			else if (cp < 21'h800)
				n = 2'd1;
			else if (cp < 21'h10000)
				n = 2'd2;
			else
				n = 2'd3;
			return n;
		end
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [7:0] b;
		begin
			b = 8'h00;
			unique case (utf8_last(cp))
				2'd0: b = cp[7:0];
				2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
				2'd2: begin
					if (idx == 2'd0)
						b = {4'b1110, cp[15:12]};
					else if (idx == 2'd1)
						b = {2'b10, cp[11:6]};
					else
						b = {2'b10, cp[5:0]};
				end
				default: begin
					if (idx == 2'd0)
						b = {5'b11110, cp[20:18]};
					else if (idx == 2'd1)
						b = {2'b10, cp[17:12]};
					else if (idx == 2'd2)
						b = {2'b10, cp[11:6]};
					else
						b = {2'b10, cp[5:0]};
				end
			endcase
			return b;
		end
	endfunction

endpackage

// ===== design/ste_front.sv =====
// Front end: parses the script byte stream, issuing at most one result group
// per accepted byte. Depends on ste_pkg.
module ste_front
	import ste_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	output logic       cmd_push,
	output cmd_t       cmd
);

	mode_t       mode_q, mode_n;
	logic [7:0]  prev_byte_q, prev_byte_n;
	logic        prev_valid_q, prev_valid_n;
	logic [7:0]  units_q, units_n;
	logic [7:0]  low_q, low_n;
	logic [9:0]  pend_hi_q, pend_hi_n;
	logic        pend_v_q, pend_v_n;
	logic        stopped_q, stopped_n;

	logic [15:0] unit;
	logic        u_zero, u_hi, u_lo;
	logic [7:0]  units_dec;
	logic        units_done;
	logic        pv_after;
	logic [20:0] cp_pair;

	assign unit       = {in_byte, low_q};
	assign u_zero     = (unit == 16'h0000);
	assign u_hi       = (unit[15:10] == SURR_HIGH);
	assign u_lo       = (unit[15:10] == SURR_LOW);
	assign units_dec  = units_q - 8'd1;
	assign units_done = (units_dec == 8'd0);
	assign pv_after   = stopped_q ? pend_v_q : u_hi;
	assign cp_pair    = CP_SUPP_BASE + {1'b0, pend_hi_q, unit[9:0]};

	always_comb begin
		mode_n       = mode_q;
		prev_byte_n  = prev_byte_q;
		prev_valid_n = prev_valid_q;
		units_n      = units_q;
		low_n        = low_q;
		pend_hi_n    = pend_hi_q;
		pend_v_n     = pend_v_q;
		stopped_n    = stopped_q;
		unique case (mode_q)
			MODE_TEXT_LEN: begin
				units_n   = in_byte;
				pend_v_n  = 1'b0;
				pend_hi_n = 10'd0;
				stopped_n = 1'b0;
				if (in_byte == 8'd0) begin
					mode_n       = MODE_SCAN;
					prev_valid_n = 1'b0;
					prev_byte_n  = 8'd0;
				end else begin
					mode_n = MODE_TEXT_LO;
				end
			end
			MODE_SKIP_LEN: begin
				units_n = in_byte;
				if (in_byte == 8'd0) begin
					mode_n       = MODE_SCAN;
					prev_valid_n = 1'b0;
					prev_byte_n  = 8'd0;
				end else begin
					mode_n = MODE_SKIP_LO;
				end
			end
			MODE_TEXT_LO: begin
				low_n  = in_byte;
				mode_n = MODE_TEXT_HI;
			end
			MODE_TEXT_HI: begin
				if (!stopped_q) begin
					if (u_zero) begin
						pend_v_n  = 1'b0;
						stopped_n = 1'b1;
					end else if (u_hi) begin
						pend_v_n  = 1'b1;
						pend_hi_n = unit[9:0];
					end else begin
						pend_v_n = 1'b0;
					end
				end
				units_n = units_dec;
				if (units_done) begin
					pend_v_n     = 1'b0;
					stopped_n    = 1'b0;
					mode_n       = MODE_SCAN;
					prev_valid_n = 1'b0;
					prev_byte_n  = 8'd0;
				end else begin
					mode_n = MODE_TEXT_LO;
				end
			end
			MODE_SKIP_LO: begin
				mode_n = MODE_SKIP_HI;
			end
			MODE_SKIP_HI: begin
				units_n = units_dec;
				if (units_done) begin
					mode_n       = MODE_SCAN;
					prev_valid_n = 1'b0;
					prev_byte_n  = 8'd0;
				end else begin
					mode_n = MODE_SKIP_LO;
				end
			end
			default: begin
				if (prev_valid_q && in_byte == OP_SECOND &&
				    (prev_byte_q == OP_TEXT_A || prev_byte_q == OP_TEXT_B)) begin
					mode_n       = MODE_TEXT_LEN;
					prev_valid_n = 1'b0;
				end else if (prev_valid_q && in_byte == OP_SECOND &&
				             prev_byte_q == OP_SKIP) begin
					mode_n       = MODE_SKIP_LEN;
					prev_valid_n = 1'b0;
				end else begin
					mode_n       = MODE_SCAN;
					prev_byte_n  = in_byte;
					prev_valid_n = 1'b1;
				end
			end
		endcase
		if (end_of_file) begin
			mode_n       = MODE_SCAN;
			prev_byte_n  = 8'd0;
			prev_valid_n = 1'b0;
			units_n      = 8'd0;
			low_n        = 8'd0;
			pend_hi_n    = 10'd0;
			pend_v_n     = 1'b0;
			stopped_n    = 1'b0;
		end
	end

	always_comb begin
		cmd = '0;
		unique case (mode_q)
			MODE_TEXT_LEN: begin
				cmd.crlf = (in_byte == 8'd0);
			end
			MODE_TEXT_HI: begin
				if (!stopped_q) begin
					if (u_zero || u_hi) begin
						cmd.pre = pend_v_q;
					end else if (u_lo) begin
						cmd.cpv = 1'b1;
						cmd.cp  = pend_v_q ? cp_pair : CP_REPLACE;
					end else begin
						cmd.pre = pend_v_q;
						cmd.cpv = 1'b1;
						cmd.cp  = {5'd0, unit};
					end
				end
				cmd.post = units_done && pv_after;
				cmd.crlf = units_done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign cmd_push = accept && (cmd.pre || cmd.cpv || cmd.post || cmd.crlf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SCAN;
			prev_byte_q  <= 8'd0;
			prev_valid_q <= 1'b0;
			units_q      <= 8'd0;
			low_q        <= 8'd0;
			pend_hi_q    <= 10'd0;
			pend_v_q     <= 1'b0;
			stopped_q    <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_n;
			prev_byte_q  <= prev_byte_n;
			prev_valid_q <= prev_valid_n;
			units_q      <= units_n;
			low_q        <= low_n;
			pend_hi_q    <= pend_hi_n;
			pend_v_q     <= pend_v_n;
			stopped_q    <= stopped_n;
		end
	end

endmodule

// ===== design/ste_cmd_fifo.sv =====
// Short command queue between the parser front end and the byte emitter.
// Depends on ste_pkg.
module ste_cmd_fifo
	import ste_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic rd_valid
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_wr, do_rd;

	assign full     = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (!do_wr && do_rd)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== design/ste_back.sv =====
// Back end: expands result groups into UTF-8 and CR LF bytes, one per cycle
// while the output register is free. Depends on ste_pkg.
module ste_back
	import ste_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_take,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       empty,
	input  logic       pop
);

	logic        pre_q, cpv_q, post_q, crlf_q;
	logic [20:0] cp_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;

	logic        active;
	logic        seg_crlf;
	logic [20:0] seg_cp;
	logic [1:0]  seg_last;
	logic        seg_end;
	logic        rest;
	logic [7:0]  byte_nx;
	logic        out_free;
	logic        emit;
	logic        cmd_end;

	assign active   = pre_q || cpv_q || post_q || crlf_q;
	assign seg_crlf = !pre_q && !cpv_q && !post_q;

	always_comb begin
		seg_cp   = (cpv_q && !pre_q) ? cp_q : CP_REPLACE;
		seg_last = seg_crlf ? 2'd1 : utf8_last(seg_cp);
		byte_nx  = seg_crlf ? (idx_q[0] ? CHAR_LF : CHAR_CR) : utf8_byte(seg_cp, idx_q);
		seg_end  = (idx_q == seg_last);
		priority if (pre_q)
			rest = cpv_q || post_q || crlf_q;
		else if (cpv_q)
			rest = post_q || crlf_q;
		else if (post_q)
			rest = crlf_q;
		else
			rest = 1'b0;
	end

	assign out_free = !out_valid_q || pop;
	assign emit     = active && out_free;
	assign cmd_end  = seg_end && !rest;
	assign cmd_take = cmd_valid && (!active || (emit && cmd_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q  <= 1'b0;
			cpv_q  <= 1'b0;
			post_q <= 1'b0;
			crlf_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (cmd_take) begin
			pre_q  <= cmd.pre;
			cpv_q  <= cmd.cpv;
			post_q <= cmd.post;
			crlf_q <= cmd.crlf;
			idx_q  <= 2'd0;
		end else if (emit) begin
			if (seg_end) begin
				idx_q <= 2'd0;
				priority if (pre_q)
					pre_q <= 1'b0;
				else if (cpv_q)
					cpv_q <= 1'b0;
				else if (post_q)
					post_q <= 1'b0;
				else
					crlf_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take)
			cp_q <= cmd.cp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_nx;
			run_last_q <= cmd_end;
		end
	end

	assign out_byte = out_byte_q;
	assign run_last = run_last_q;
	assign empty    = !out_valid_q;

endmodule

// ===== design/script_text_extractor_top.sv =====
// Top level of the script text extractor: parser front end, command queue, byte emitter.
// Depends on ste_pkg, ste_front, ste_cmd_fifo and ste_back.
//
// Input queue port: in_byte and end_of_file are taken when push is high and full is low.
// Output queue port: out_byte and run_last are valid while empty is low; a result is
// taken when pop is high. run_last marks the final byte caused by one input byte.
//
// While full is low, the parser takes one input byte per cycle and turns each byte into
// at most one result group (replacement char, code point, replacement char, CR LF),
// which goes into a four-entry command queue. While the receiver pops, the emitter
// drains that queue one output byte per cycle with no gap between groups, so throughput
// is bounded by the output: one input per cycle while the queue has room, otherwise
// one output byte per cycle. Each result passes the queue, emitter and output register.
//
// Reset clears the parser state, the queue and the output valid flag; empty is high
// and full low afterward. When the receiver stops popping, the output register holds,
// the emitter stalls, the queue fills and full rises; input bytes that produce no
// result are still taken while the queue is not full.
module script_text_extractor_top
	import ste_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       empty,
	input  logic       pop
);

	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_valid;
	logic cmd_take;

	assign accept = push && !full;

	ste_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.end_of_file (end_of_file),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	ste_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (cmd_in),
		.full     (full),
		.rd_en    (cmd_take),
		.rd_data  (cmd_out),
		.rd_valid (cmd_valid)
	);

	ste_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_take  (cmd_take),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== design/ste_checker.sv =====
// Port-level checks for the script text extractor, bound to the top level.
// Depends on script_text_extractor_top.
module ste_checker (
	input logic       clk,
	input logic       arst_n,
	input logic [7:0] in_byte,
	input logic       end_of_file,
	input logic       push,
	input logic       full,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       empty,
	input logic       pop
);

	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (empty && !full))
		else $error("ports not idle after reset");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without an input transaction");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_last)))
		else $error("waiting result changed before pop");

endmodule

bind script_text_extractor_top ste_checker u_ste_checker (.*);
